>>> design/utf8v_pkg.sv
// Shared types and constants for the UTF-8 string validator.
package utf8v_pkg;

  // Sequence length classes kept in lead_class
  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_TWO   = 2'd1;
  localparam logic [1:0] CLASS_THREE = 2'd2;
  localparam logic [1:0] CLASS_FOUR  = 2'd3;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Code point limits
  localparam logic [20:0] MIN_TWO   = 21'h000080;
  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_FOUR  = 21'h010000;
  localparam logic [20:0] MAX_POINT = 21'h10ffff;
  localparam logic [20:0] SURR_LO   = 21'h00d800;
  localparam logic [20:0] SURR_HI   = 21'h00dfff;

  typedef struct packed {
    logic [1:0]  pending_count;
    logic [20:0] partial_point;
    logic [1:0]  lead_class;
    logic        error_seen;
  } state_t;

endpackage

>>> design/utf8v_step.sv
// Per-byte decode step: next validator state and verdict on a final byte.
module utf8v_step (
  input  utf8v_pkg::state_t state,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output utf8v_pkg::state_t state_next,
  output logic              string_valid
);
  import utf8v_pkg::*;

  state_t      mid;
  logic [20:0] point;
  logic [1:0]  pend;
  logic [20:0] minimum;

  assign point   = {state.partial_point[14:0], data_byte[5:0]};
  assign pend    = state.pending_count - 2'd1;
  assign minimum = (state.lead_class == CLASS_TWO)   ? MIN_TWO :
                   (state.lead_class == CLASS_THREE) ? MIN_THREE : MIN_FOUR;

  always_comb begin
    mid = state;
    if (!state.error_seen) begin
      if (state.pending_count == 2'd0) begin
        if (data_byte[7] == 1'b0) begin
          if (data_byte == 8'h00) mid.error_seen = 1'b1;
        end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
          mid.pending_count = 2'd1;
          mid.partial_point = {16'd0, data_byte[4:0]};
          mid.lead_class    = CLASS_TWO;
        end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
          mid.pending_count = 2'd2;
          mid.partial_point = {17'd0, data_byte[3:0]};
          mid.lead_class    = CLASS_THREE;
        end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
          mid.pending_count = 2'd3;
          mid.partial_point = {18'd0, data_byte[2:0]};
          mid.lead_class    = CLASS_FOUR;
        end else begin
          mid.error_seen = 1'b1;
        end
      end else if ((data_byte & CONT_MASK) != CONT_TAG) begin
        // broken sequence: drop it, error is sticky
        mid = '0;
        mid.error_seen = 1'b1;
      end else if (pend != 2'd0) begin
        mid.partial_point = point;
        mid.pending_count = pend;
      end else begin
        // sequence complete: overlong, out of range, surrogate
        mid = '0;
        mid.error_seen = (point < minimum) || (point > MAX_POINT) ||
                         (point >= SURR_LO && point <= SURR_HI);
      end
    end
  end

  always_comb begin
    state_next   = mid;
    string_valid = !mid.error_seen && (mid.pending_count == 2'd0);
    if (last_byte) state_next = '0;
  end

endmodule

>>> design/utf8_string_validator_top.sv
// Top level of the strict UTF-8 string validator.
// Takes one string byte per item on s_axis, tlast on its final byte, and
// for that final byte alone delivers one item on m_axis whose bit 0 is 1
// when the whole string is strict UTF-8 (shortest form, no NUL, no
// surrogates, nothing above U+10FFFF, no truncated sequence at the end).
// Bytes without tlast give no output item. Throughput is one byte per
// cycle: the byte goes to an input register, one short decode step
// updates the string state and, on a final byte, loads the result
// register, which drives m_axis. Input is held off only while a final
// byte's verdict waits in a result register that is not being taken.
// All string state clears after each final byte.
module utf8_string_validator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] string_valid, [7:1] zero
);
  import utf8v_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // string state and result register
  state_t state;
  state_t state_next;
  logic   verdict_next;
  logic   verdict;

  logic advance;

  // the held byte moves on unless it is a final byte blocked by a full output
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  utf8v_step u_step (
    .state        (state),
    .data_byte    (in_byte),
    .last_byte    (in_last),
    .state_next   (state_next),
    .string_valid (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      verdict <= verdict_next;
    end
  end

  assign m_axis_tdata = {7'd0, verdict};

`ifndef SYNTHESIS
  // an open sequence always has a length class at least as large as its count
  a_pend_class: assert property (@(posedge clk) disable iff (rst)
    state.pending_count <= state.lead_class)
    else $error("pending count exceeds lead class");

  // an error drops any open sequence
  a_err_closed: assert property (@(posedge clk) disable iff (rst)
    state.error_seen |-> (state.pending_count == 2'd0))
    else $error("open sequence after error");

  // state clears after a final byte
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (state == '0))
    else $error("state not cleared after final byte");

  // a verdict appears only after a final byte was processed
  a_rose: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance && in_last))
    else $error("output without final byte");

  // a final byte never overwrites an untaken verdict
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(advance && in_last))
    else $error("verdict overwritten");
`endif

endmodule

>>> bench/utf8_verdict_board_pkg.sv
// Scoreboard that predicts and checks string verdicts of the UTF-8 validator.
package utf8_verdict_board_pkg;
  import utf8v_pkg::*;

  class utf8_verdict_board;
    logic [1:0]  need_cont;    // continuation bytes still owed
    logic [20:0] point_acc;    // code point bits gathered so far
    logic [1:0]  seq_class;    // length class of the open sequence
    logic        str_bad;      // sticky: string already known bad
    bit          verdicts_due[$];
    int          failures;
    int          judged;
    int          judged_valid;

    function new();
      drop_sequence();
      str_bad      = 1'b0;
      failures     = 0;
      judged       = 0;
      judged_valid = 0;
    endfunction

    function void drop_sequence();
      need_cont = 2'd0;
      point_acc = '0;
      seq_class = CLASS_NONE;
    endfunction

    function int outstanding();
      return verdicts_due.size();
    endfunction

    // Advance the string state by one accepted byte; a final byte queues a verdict.
    function void take_byte(logic [7:0] data_byte, logic last_byte);
      logic [20:0] floor_pt;
      if (!str_bad) begin
        if (need_cont == 2'd0) begin
          if (data_byte <= 8'h7f) begin
            if (data_byte == 8'h00) str_bad = 1'b1;
          end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            need_cont = 2'd1;
            point_acc = {16'd0, data_byte[4:0]};
            seq_class = CLASS_TWO;
          end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
            need_cont = 2'd2;
            point_acc = {17'd0, data_byte[3:0]};
            seq_class = CLASS_THREE;
          end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
            need_cont = 2'd3;
            point_acc = {18'd0, data_byte[2:0]};
            seq_class = CLASS_FOUR;
          end else begin
            str_bad = 1'b1;
          end
        end else if ((data_byte & CONT_MASK) != CONT_TAG) begin
          // open sequence is abandoned; byte is not re-read as a lead
          str_bad = 1'b1;
          drop_sequence();
        end else begin
          point_acc = {point_acc[14:0], data_byte[5:0]};
          need_cont = need_cont - 2'd1;
          if (need_cont == 2'd0) begin
            if (seq_class == CLASS_TWO)        floor_pt = MIN_TWO;
            else if (seq_class == CLASS_THREE) floor_pt = MIN_THREE;
            else                               floor_pt = MIN_FOUR;
            if (point_acc < floor_pt || point_acc > MAX_POINT ||
                (point_acc >= SURR_LO && point_acc <= SURR_HI))
              str_bad = 1'b1;
            drop_sequence();
          end
        end
      end
      if (last_byte) begin
        if (need_cont != 2'd0) str_bad = 1'b1;
        verdicts_due.push_back(!str_bad);
        drop_sequence();
        str_bad = 1'b0;
      end
    endfunction

    // Compare one output item with the oldest pending verdict.
    function void match_verdict(logic [7:0] tdata);
      bit want;
      if (verdicts_due.size() == 0) begin
        $error("verdict item with none pending: tdata=%02h", tdata);
        failures++;
        return;
      end
      want = verdicts_due.pop_front();
      judged++;
      if (want) judged_valid++;
      if (tdata[0] !== want) begin
        $error("string_valid mismatch: expected %0d actual %0b", want, tdata[0]);
        failures++;
      end
      if (tdata[7:1] !== 7'd0) begin
        $error("tdata[7:1] pad mismatch: expected 0 actual %02h", tdata[7:1]);
        failures++;
      end
    endfunction
  endclass

endpackage

>>> bench/tb_utf8_string_validator_top.sv
// Testbench for the strict UTF-8 string validator top level.
module tb_utf8_string_validator_top;
  import utf8_verdict_board_pkg::*;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] data_byte
  logic       s_axis_tlast;    // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;    // [0] string_valid, [7:1] zero

  utf8_verdict_board book;
  logic [7:0]        str_bytes[$];   // bytes of the string being built
  int                bytes_sent;
  int                strings_sent;
  bit                idle_on;        // both sides insert gaps when set

  utf8_string_validator_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One byte on the input stream. Valid is only lowered when a gap follows,
  // so back-to-back items never see a low/high pair in one time step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    book.take_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    strings_sent++;
    str_bytes.delete();
  endtask

  // Encode a code point in exactly len bytes; a longer len than needed
  // gives an overlong form on purpose.
  task automatic put_point(input logic [20:0] cp, input int len);
    case (len)
      1: str_bytes.push_back(cp[7:0]);
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int min_len(logic [20:0] cp);
    if (cp < 21'h80)    return 1;
    if (cp < 21'h800)   return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // A legal scalar value, with boundary values now and then.
  function automatic logic [20:0] good_point();
    logic [20:0] edges[9];
    logic [20:0] cp;
    edges = '{21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hd7ff, 21'he000,
              21'hffff, 21'h10000, 21'h10ffff};
    case ($urandom_range(0, 4))
      0: cp = 21'($urandom_range(1, 8'h7f));
      1: cp = 21'($urandom_range(8'h80, 12'h7ff));
      2: begin
        cp = 21'($urandom_range(12'h800, 16'hffff));
        if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h2000;
      end
      3: cp = 21'($urandom_range(17'h10000, 21'h10ffff));
      default: cp = edges[$urandom_range(0, 8)];
    endcase
    return cp;
  endfunction

  // One ill-formed sequence: overlong, surrogate, out of range or NUL.
  task automatic put_bad_point();
    logic [20:0] cp;
    int          len;
    case ($urandom_range(0, 3))
      0: begin
        cp  = good_point();
        len = min_len(cp);
        if (len < 4) put_point(cp, $urandom_range(len + 1, 4));
        else put_point(21'($urandom_range(16'hd800, 16'hdfff)), 3);
      end
      1: put_point(21'($urandom_range(16'hd800, 16'hdfff)), 3);
      2: put_point(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
      default: put_point(21'h0, 1);
    endcase
  endtask

  task automatic put_good_run(input int n);
    logic [20:0] cp;
    for (int i = 0; i < n; i++) begin
      cp = good_point();
      put_point(cp, min_len(cp));
    end
  endtask

  // One random string; mostly well formed, the rest broken in various ways.
  task automatic build_random_string();
    logic [20:0] cp;
    int          r, n, len;
    r = $urandom_range(0, 99);
    n = $urandom_range(1, 6);
    if (r < 62) begin
      put_good_run(n);
    end else if (r < 80) begin
      // one bad sequence somewhere inside otherwise good text
      put_good_run($urandom_range(0, n - 1));
      put_bad_point();
      put_good_run($urandom_range(0, 2));
    end else if (r < 90) begin
      // string ends part way through a multi-byte sequence
      put_good_run($urandom_range(0, 3));
      cp  = 21'($urandom_range(8'h80, 21'h10ffff));
      if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h2000;
      len = min_len(cp);
      put_point(cp, len);
      for (int k = $urandom_range(1, len - 1); k > 0; k--) void'(str_bytes.pop_back());
    end else if (r < 96) begin
      // good text with one byte overwritten
      put_good_run(n);
      str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      for (int i = 0; i < n + 2; i++) str_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Verdict side: random back-pressure, plus two long hold-offs while the
  // sender keeps offering, so the result register fills and input stalls.
  initial begin : verdict_sink
    int stall_left;
    int taken;
    stall_left = 0;
    taken      = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        book.match_verdict(m_axis_tdata);
        taken++;
        if (taken == 20 || taken == 80) stall_left = 250;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hard stop in case the handshake locks up.
  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int drain;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    bytes_sent    = 0;
    strings_sent  = 0;
    idle_on       = 1'b1;
    book          = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings: some lead range boundaries and each error kind.
    str_bytes = '{8'h00};                      send_string();  // NUL
    str_bytes = '{8'h7f};                      send_string();  // top of ASCII
    str_bytes = '{8'hff, 8'hc2, 8'h80};        send_string();  // bad lead, rest ignored
    str_bytes = '{8'hc1, 8'hbf};               send_string();  // overlong pair
    str_bytes = '{8'hc2, 8'h80};               send_string();  // smallest pair
    str_bytes = '{8'he0, 8'h9f, 8'hbf};        send_string();  // overlong triple
    str_bytes = '{8'hed, 8'ha0, 8'h80};        send_string();  // surrogate
    str_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_string();  // above U+10FFFF
    str_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; send_string();  // U+10FFFF itself
    str_bytes = '{8'he2, 8'h41};               send_string();  // ASCII mid-sequence
    str_bytes = '{8'hc3};                      send_string();  // final byte is a lead
    str_bytes = '{8'he2, 8'h82};               send_string();  // truncated triple

    // Random strings; a stretch in the middle runs without any idling.
    while (bytes_sent < 1345) begin
      idle_on = !(strings_sent >= 45 && strings_sent < 70);
      build_random_string();
      send_string();
    end
    idle_on = 1'b1;
    s_axis_tvalid <= 1'b0;

    // Let every verdict come out, then wait on for any stray items.
    while (book.outstanding() != 0) @(posedge clk);
    for (drain = 0; drain < 8; drain++) @(posedge clk);

    $display("Checked %0d strings (%0d bytes): %0d judged valid, %0d invalid.",
             book.judged, bytes_sent, book.judged_valid,
             book.judged - book.judged_valid);
    if (book.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/utf8v_pkg.sv
design/utf8v_step.sv
design/utf8_string_validator_top.sv
bench/utf8_verdict_board_pkg.sv
bench/tb_utf8_string_validator_top.sv
